// ----- hw/rtl/mrcs_pkg.sv -----
// Shared types and constants for the matrix row/column statistics block.
// Used by the front, queue, back and top-level modules; no dependencies.
package mrcs_pkg;

  localparam int ELEM_W    = 32;  // element and extreme width on the ports
  localparam int SUM_W     = 42;  // running sum width
  localparam int ROW_CNT_W = 11;  // row_count register width
  localparam int COL_CNT_W = 6;   // column_count register width
  localparam int COL_IDX_W = 6;   // column index carried in a queue entry
  localparam int ROW_IDX_W = 10;  // row index, also the line_index width
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 11;
  localparam int OUT_DAT_W = 120; // line_index, total, largest, smallest, padded

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd1;

  localparam logic KIND_ROW    = 1'b0;
  localparam logic KIND_COLUMN = 1'b1;

  // One classified element, front to back.
  typedef struct packed {
    logic [ELEM_W-1:0]    element;
    logic [COL_IDX_W-1:0] col;
    logic [ROW_IDX_W-1:0] row;
    logic                 row_first;   // element sits in row 0
    logic                 col_first;   // element sits in column 0
    logic                 row_end;
    logic                 matrix_end;
  } item_t;

  // Sum and extremes of one line.
  typedef struct packed {
    logic [SUM_W-1:0]  total;
    logic [ELEM_W-1:0] largest;
    logic [ELEM_W-1:0] smallest;
  } stats_t;

  localparam int STATS_W = $bits(stats_t);

  typedef struct packed {
    logic                 kind;
    logic [ROW_IDX_W-1:0] line_index;
    stats_t               stats;
    logic                 last;
  } result_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_DRAIN_RD,
    BK_DRAIN_WAIT
  } back_state_t;

endpackage

// ----- hw/rtl/matrix_row_column_statistics.sv -----
// Top level of the matrix row/column statistics block: front, queue, back.
// Depends on mrcs_pkg, mrcs_front, mrcs_queue, mrcs_back (and mrcs_ram).
//
//   channel   dir  payload                                    request when
//   s_axis    in   element                                    tvalid & tready
//   m_axis    out  line_index,total,largest,smallest;kind;last tvalid & tready
//   cfg       in   cfg_index selects row_count/column_count    cfg_valid & cfg_ready
//
// One element per cycle while results are taken and no drain runs. At
// matrix end the column store (one read port) drains column by column
// through a read and a wait state; intake stalls meanwhile once the
// two-entry queue fills. Reset clears positions and sets both counts to 1;
// the column store is not cleared. Output stalls hold the result register,
// then the back stage when it holds a row end, then the queue.
module matrix_row_column_statistics #(
  parameter int MAX_COLUMNS   = 32,
  parameter int MAX_ROWS      = 1024,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [mrcs_pkg::ELEM_W-1:0]        s_axis_tdata,  // [31:0] element
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [9:0] line_index, [51:10] total, [83:52] largest, [115:84] smallest
  output logic [mrcs_pkg::OUT_DAT_W-1:0]     m_axis_tdata,
  output logic [0:0]                         m_axis_tuser,  // [0] kind
  output logic                               m_axis_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mrcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mrcs_pkg::CFG_DAT_W-1:0]     cfg_data
);

  import mrcs_pkg::*;

  logic                 push;
  item_t                push_item;
  logic                 queue_full;
  logic                 head_valid;
  item_t                head_item;
  logic                 pop;
  logic [COL_CNT_W-1:0] cols;
  result_t              res;

  assign cfg_ready = 1'b1;

  mrcs_front #(
    .MAX_COLUMNS   (MAX_COLUMNS),
    .MAX_ROWS      (MAX_ROWS),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_element (s_axis_tdata),
    .push       (push),
    .push_item  (push_item),
    .queue_full (queue_full),
    .cols       (cols)
  );

  mrcs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  mrcs_back #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (head_valid),
    .q_item    (head_item),
    .q_pop     (pop),
    .cols      (cols),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_res   (res)
  );

  assign m_axis_tdata = {4'b0000, res.stats.smallest, res.stats.largest,
                         res.stats.total, res.line_index};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

// ----- hw/rtl/mrcs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/mrcs_front.sv -----
// Front part: configuration registers, element intake and row/column tracking.
// Depends on mrcs_pkg.
module mrcs_front #(
  parameter int MAX_COLUMNS   = 32,
  parameter int MAX_ROWS      = 1024,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [mrcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mrcs_pkg::CFG_DAT_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [mrcs_pkg::ELEM_W-1:0]        in_element,
  output logic                               push,
  output mrcs_pkg::item_t                    push_item,
  input  logic                               queue_full,
  output logic [mrcs_pkg::COL_CNT_W-1:0]     cols
);

  import mrcs_pkg::*;

  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [ROW_CNT_W-1:0] row_count;
  logic [COL_CNT_W-1:0] column_count;
  logic [ROW_CNT_W-1:0] rows;
  logic [CW-1:0]        column_position;
  logic [RW-1:0]        row_position;
  logic                 row_end;
  logic                 matrix_end;
  logic [ELEM_W-1:0]    element_ext;

  // Clamp counts into 1..MAX
  always_comb begin
    if (row_count == '0) begin
      rows = ROW_CNT_W'(1);
    end else if (row_count > ROW_CNT_W'(MAX_ROWS)) begin
      rows = ROW_CNT_W'(MAX_ROWS);
    end else begin
      rows = row_count;
    end
    if (column_count == '0) begin
      cols = COL_CNT_W'(1);
    end else if (column_count > COL_CNT_W'(MAX_COLUMNS)) begin
      cols = COL_CNT_W'(MAX_COLUMNS);
    end else begin
      cols = column_count;
    end
  end

  assign element_ext = ELEM_W'(signed'(in_element[ELEMENT_WIDTH-1:0]));
  assign row_end     = (COL_CNT_W'(column_position) + COL_CNT_W'(1)) >= cols;
  assign matrix_end  = row_end &&
                       ((ROW_CNT_W'(row_position) + ROW_CNT_W'(1)) >= rows);

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_item            = '0;
    push_item.element    = element_ext;
    push_item.col        = COL_IDX_W'(column_position);
    push_item.row        = ROW_IDX_W'(row_position);
    push_item.row_first  = (row_position == '0);
    push_item.col_first  = (column_position == '0);
    push_item.row_end    = row_end;
    push_item.matrix_end = matrix_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count       <= ROW_CNT_W'(1);
      column_count    <= COL_CNT_W'(1);
      column_position <= '0;
      row_position    <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_ROW_COUNT:    row_count    <= cfg_data;
          REG_COLUMN_COUNT: column_count <= cfg_data[COL_CNT_W-1:0];
          default: ;
        endcase
      end
      if (push) begin
        if (row_end) begin
          column_position <= '0;
          row_position    <= matrix_end ? '0 : row_position + RW'(1);
        end else begin
          column_position <= column_position + CW'(1);
        end
      end
    end
  end

endmodule

// ----- hw/rtl/mrcs_queue.sv -----
// Two-entry queue of classified elements between front and back.
// Depends on mrcs_pkg.
module mrcs_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mrcs_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output mrcs_pkg::item_t head_item
);

  import mrcs_pkg::*;

  localparam int DEPTH = 2;

  item_t      entries [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'(DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- hw/rtl/mrcs_back.sv -----
// Back part: row and column statistics, column store, result register and
// column drain at matrix end. Depends on mrcs_pkg and mrcs_ram.
module mrcs_back #(
  parameter int MAX_COLUMNS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  mrcs_pkg::item_t                q_item,
  output logic                           q_pop,
  input  logic [mrcs_pkg::COL_CNT_W-1:0] cols,
  input  logic                           out_ready,
  output logic                           out_valid,
  output mrcs_pkg::result_t              out_res
);

  import mrcs_pkg::*;

  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  back_state_t       state;
  back_state_t       state_next;
  logic [CW-1:0]     k;
  logic [CW-1:0]     k_next;
  logic              b_valid;
  item_t             b_item;
  logic              fwd_valid;
  stats_t            fwd_stats;
  stats_t            row_stats;
  stats_t            row_new;
  stats_t            col_base;
  stats_t            col_new;
  logic              out_free;
  logic              b_fire;
  logic              drain_load;
  logic              drain_last;
  logic              ram_re;
  logic [CW-1:0]     ram_raddr;
  logic [STATS_W-1:0] ram_rdata;
  logic [SUM_W-1:0]  e_sum;
  logic [ELEM_W-1:0] e;

  assign out_free   = !out_valid || out_ready;
  assign b_fire     = b_valid && (!b_item.row_end || out_free);
  assign q_pop      = q_valid && (state == BK_RUN) &&
                      (!b_valid || (b_fire && !b_item.matrix_end));
  assign drain_load = (state == BK_DRAIN_WAIT) && out_free;
  assign drain_last = (COL_CNT_W'(k) + COL_CNT_W'(1)) == cols;

  assign e     = b_item.element;
  assign e_sum = SUM_W'(signed'(e));

  // A write landing on the same edge as the read is not seen by the RAM
  assign col_base = fwd_valid ? fwd_stats : stats_t'(ram_rdata);

  always_comb begin
    if (b_item.col_first) begin
      row_new.total    = e_sum;
      row_new.largest  = e;
      row_new.smallest = e;
    end else begin
      row_new.total    = row_stats.total + e_sum;
      row_new.largest  = ($signed(e) > $signed(row_stats.largest)) ? e : row_stats.largest;
      row_new.smallest = ($signed(e) < $signed(row_stats.smallest)) ? e : row_stats.smallest;
    end
    if (b_item.row_first) begin
      col_new.total    = e_sum;
      col_new.largest  = e;
      col_new.smallest = e;
    end else begin
      col_new.total    = col_base.total + e_sum;
      col_new.largest  = ($signed(e) > $signed(col_base.largest)) ? e : col_base.largest;
      col_new.smallest = ($signed(e) < $signed(col_base.smallest)) ? e : col_base.smallest;
    end
  end

  assign ram_re    = q_pop || (state == BK_DRAIN_RD);
  assign ram_raddr = (state == BK_DRAIN_RD) ? k : q_item.col[CW-1:0];

  mrcs_ram #(
    .WIDTH (STATS_W),
    .DEPTH (MAX_COLUMNS)
  ) u_col_ram (
    .clk   (clk),
    .we    (b_fire),
    .waddr (b_item.col[CW-1:0]),
    .wdata (col_new),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    k_next     = k;
    case (state)
      BK_RUN: begin
        if (b_fire && b_item.matrix_end) begin
          state_next = BK_DRAIN_RD;
          k_next     = '0;
        end
      end
      BK_DRAIN_RD: begin
        state_next = BK_DRAIN_WAIT;
      end
      BK_DRAIN_WAIT: begin
        if (drain_load) begin
          if (drain_last) begin
            state_next = BK_RUN;
          end else begin
            state_next = BK_DRAIN_RD;
            k_next     = k + CW'(1);
          end
        end
      end
      default: begin
        state_next = BK_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_RUN;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      fwd_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        b_valid   <= 1'b1;
        fwd_valid <= b_fire && (b_item.col == q_item.col);
      end else if (b_fire) begin
        b_valid <= 1'b0;
      end
      if (b_fire && b_item.row_end) begin
        out_valid <= 1'b1;
      end else if (drain_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_item    <= q_item;
      fwd_stats <= col_new;
    end
    if (b_fire) begin
      row_stats <= row_new;
    end
    if (b_fire && b_item.row_end) begin
      out_res.kind       <= KIND_ROW;
      out_res.line_index <= b_item.row;
      out_res.stats      <= row_new;
      out_res.last       <= !b_item.matrix_end;
    end else if (drain_load) begin
      out_res.kind       <= KIND_COLUMN;
      out_res.line_index <= ROW_IDX_W'(k);
      out_res.stats      <= stats_t'(ram_rdata);
      out_res.last       <= drain_last;
    end
  end

  logic k_in_range;
  assign k_in_range = COL_CNT_W'(k) < cols;

  a_no_pop_in_drain: assert property (@(posedge clk) disable iff (rst)
    (state != BK_RUN) |-> !q_pop)
    else $error("queue popped during column drain");

  a_drain_after_end: assert property (@(posedge clk) disable iff (rst)
    (b_fire && b_item.matrix_end) |=> (state == BK_DRAIN_RD))
    else $error("matrix end did not start the column drain");

  a_drain_index: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DRAIN_WAIT) |-> k_in_range)
    else $error("drain index beyond column count");

  a_drain_stage_empty: assert property (@(posedge clk) disable iff (rst)
    (state != BK_RUN) |-> !b_valid)
    else $error("element in flight during column drain");

endmodule
